>>> src/srb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Retransmit buffer package
// Shared widths, request codes and the remainder unit status word.
// ----------------------------------------------------------------------------
package srb_pkg;

	// field widths
	localparam int SEQ_W     = 32;
	localparam int PAY_W     = 32;
	localparam int REQ_W     = 2;
	localparam int CAP_W     = 6;
	localparam int SLOTS_DEF = 32;

	// capacity register value after reset
	localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

	// request codes
	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH  = 2'd0,
		REQ_PULL  = 2'd1,
		REQ_FLUSH = 2'd2,
		REQ_NOP   = 2'd3
	} req_t;

	// remainder unit status
	typedef struct packed {
		logic busy;
		logic done;
	} srb_mod_sts_t;

endpackage : srb_pkg
`default_nettype wire

>>> src/srb_mod.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sequence remainder unit
// Bit-serial restoring remainder of a 32-bit sequence number by the slot
// count; one dividend bit per cycle, done pulses once all SEQ_W bits are in.
// ----------------------------------------------------------------------------
module srb_mod import srb_pkg::*; #(
	parameter int DIV_W = 6
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [SEQ_W-1:0] dividend,
	input  wire logic [DIV_W-1:0] divisor,
	output srb_mod_sts_t          sts,
	output logic      [DIV_W-1:0] rem
);

	localparam int STEP_W = $clog2(SEQ_W);

	logic [SEQ_W-1:0]  dvd_q;
	logic [DIV_W-1:0]  div_q;
	logic [DIV_W-1:0]  rem_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_W:0]    trial;
	logic              trial_ge;
	logic [DIV_W-1:0]  rem_nx;

	// one restoring step: shift in the next bit, subtract if it fits
	always_comb begin
		trial    = {rem_q, dvd_q[SEQ_W-1]};
		trial_ge = (trial >= {1'b0, div_q});
		if (trial_ge) begin
			rem_nx = DIV_W'(trial - {1'b0, div_q});
		end else begin
			rem_nx = trial[DIV_W-1:0];
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(SEQ_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[SEQ_W-2:0], 1'b0};
			rem_q <= rem_nx;
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign rem      = rem_q;

endmodule : srb_mod
`default_nettype wire

>>> src/sequence_retransmit_buffer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sequence retransmit buffer
// Ring of payload slots indexed by sequence number modulo the capacity in
// use, holding the window [oldest, next) with eviction, range pulls and flush.
// ----------------------------------------------------------------------------
// One request word is taken at a time. The slot index of a sequence number
// comes from a bit-serial remainder unit. A push checks the window; when it
// evicts old entries it first finds the oldest slot and clears the evicted
// slots, one per cycle, then takes the remainder for its own slot. A pull
// clamps its range, takes the remainder of its first sequence and walks the
// payload memory through its single read port, one slot per cycle, but each
// present entry and any output stall hold the walk. A pull whose clamped
// range is empty skips the remainder. A flush or an unused code completes in
// the idle state. Valid bits are flip-flops cleared by reset and flush, so no
// clearing pass is needed. A finished result waits in the output register
// while the next request word is accepted.
// ----------------------------------------------------------------------------
module sequence_retransmit_buffer_unit import srb_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// capacity register
	input  wire logic             cfg_wr_en,
	input  wire logic [CAP_W-1:0] cfg_wr_data,
	// request channel
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [REQ_W-1:0] req_type,
	input  wire logic [SEQ_W-1:0] seq_num,
	input  wire logic [SEQ_W-1:0] range_end,
	input  wire logic [PAY_W-1:0] payload,
	// result channel
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic                  present,
	output logic      [SEQ_W-1:0] out_seq,
	output logic      [PAY_W-1:0] out_payload,
	output logic                  last
);

	localparam int CW = $clog2(SLOTS + 1);
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b000_0000_0001,
		ST_PCHK  = 11'b000_0000_0010,
		ST_EVMOD = 11'b000_0000_0100,
		ST_EVICT = 11'b000_0000_1000,
		ST_PMOD  = 11'b000_0001_0000,
		ST_LCHK  = 11'b000_0010_0000,
		ST_LLEN  = 11'b000_0100_0000,
		ST_LMOD  = 11'b000_1000_0000,
		ST_WALK  = 11'b001_0000_0000,
		ST_RDATA = 11'b010_0000_0000,
		ST_LAST  = 11'b100_0000_0000
	} state_t;

	state_t            state_q;
	logic [CAP_W-1:0]  capacity_q;
	logic [CW-1:0]     cap_eff;

	// request latches
	logic [REQ_W-1:0]  req_q;
	logic [SEQ_W-1:0]  seq_q;
	logic [SEQ_W-1:0]  end_q;
	logic [PAY_W-1:0]  pay_q;

	// window marks and slot state
	logic [SEQ_W-1:0]  oldest_q;
	logic [SEQ_W-1:0]  next_q;
	logic [SLOTS-1:0]  valid_q;
	logic [PAY_W-1:0]  mem [SLOTS];
	logic [PAY_W-1:0]  rdata_q;

	// walker
	logic [IW-1:0]     walk_idx_q;
	logic [CW-1:0]     cnt_q;
	logic [IW-1:0]     walk_idx_nx;

	// held entry, emitted once the next one (or the end) is known
	logic              pend_vld_q;
	logic [SEQ_W-1:0]  pend_seq_q;
	logic [PAY_W-1:0]  pend_pay_q;

	// output register
	logic              out_valid_q;
	logic              present_q;
	logic [SEQ_W-1:0]  out_seq_q;
	logic [PAY_W-1:0]  out_pay_q;
	logic              last_q;
	logic              out_free;
	logic              out_load;
	logic              ld_present;
	logic [SEQ_W-1:0]  ld_seq;
	logic [PAY_W-1:0]  ld_pay;
	logic              ld_last;

	// push checks
	logic [SEQ_W-1:0]  span_diff;
	logic [SEQ_W:0]    span;
	logic [SEQ_W:0]    excess;
	logic              do_evict;
	logic [CW-1:0]     nclr;

	// pull length
	logic [SEQ_W-1:0]  len_diff;
	logic [CW-1:0]     len;

	// remainder unit
	logic              mod_start;
	logic [SEQ_W-1:0]  mod_dvd;
	srb_mod_sts_t      mod_sts;
	logic [CW-1:0]     mod_rem;
	logic [IW-1:0]     mod_idx;

	logic              in_acc;
	logic              walk_hit;

	// capacity clamp to 1..SLOTS
	always_comb begin
		if (capacity_q == '0) begin
			cap_eff = CW'(1);
		end else if (int'(capacity_q) > SLOTS) begin
			cap_eff = CW'(SLOTS);
		end else begin
			cap_eff = CW'(capacity_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			capacity_q <= cfg_wr_data;
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;

	// window span for a push
	always_comb begin
		span_diff = seq_q - oldest_q;
		span      = {1'b0, span_diff} + (SEQ_W+1)'(1);
		excess    = span - (SEQ_W+1)'(cap_eff);
		do_evict  = (span > (SEQ_W+1)'(cap_eff));
		if (excess < (SEQ_W+1)'(cap_eff)) begin
			nclr = excess[CW-1:0];
		end else begin
			nclr = cap_eff;
		end
	end

	// clamped pull length
	always_comb begin
		len_diff = end_q - seq_q;
		if (len_diff > SEQ_W'(cap_eff)) begin
			len = cap_eff;
		end else begin
			len = len_diff[CW-1:0];
		end
	end

	// ring increment of the walk index
	always_comb begin
		if ((CW'(walk_idx_q) + CW'(1)) == cap_eff) begin
			walk_idx_nx = '0;
		end else begin
			walk_idx_nx = IW'(walk_idx_q + 1'b1);
		end
	end

	assign walk_hit = valid_q[walk_idx_q];

	// remainder requests
	always_comb begin
		mod_start = 1'b0;
		mod_dvd   = seq_q;
		case (state_q)
			ST_PCHK: begin
				mod_start = (seq_q >= next_q);
				if (do_evict) begin
					mod_dvd = oldest_q;
				end
			end
			ST_EVICT: begin
				mod_start = (cnt_q == CW'(1));
			end
			ST_LLEN: begin
				mod_start = (seq_q < end_q);
			end
			default: begin
				mod_start = 1'b0;
			end
		endcase
	end

	srb_mod #(
		.DIV_W (CW)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (mod_dvd),
		.divisor  (cap_eff),
		.sts      (mod_sts),
		.rem      (mod_rem)
	);

	assign mod_idx = mod_rem[IW-1:0];

	// output register loading
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		out_load   = 1'b0;
		ld_present = 1'b0;
		ld_seq     = '0;
		ld_pay     = '0;
		ld_last    = 1'b1;
		case (state_q)
			ST_RDATA: begin
				out_load   = pend_vld_q && out_free;
				ld_present = 1'b1;
				ld_seq     = pend_seq_q;
				ld_pay     = pend_pay_q;
				ld_last    = 1'b0;
			end
			ST_LAST: begin
				out_load = out_free;
				if (pend_vld_q) begin
					ld_present = 1'b1;
					ld_seq     = pend_seq_q;
					ld_pay     = pend_pay_q;
				end
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			oldest_q   <= '0;
			next_q     <= '0;
			valid_q    <= '0;
			pend_vld_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (req_type)
							REQ_PUSH: begin
								state_q <= ST_PCHK;
							end
							REQ_PULL: begin
								state_q <= ST_LCHK;
							end
							REQ_FLUSH: begin
								valid_q  <= '0;
								oldest_q <= '0;
								next_q   <= '0;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_PCHK: begin
					if (seq_q < next_q) begin
						state_q <= ST_IDLE;
					end else if (do_evict) begin
						oldest_q <= oldest_q + excess[SEQ_W-1:0];
						state_q  <= ST_EVMOD;
					end else begin
						state_q <= ST_PMOD;
					end
				end
				ST_EVMOD: begin
					if (mod_sts.done) begin
						state_q <= ST_EVICT;
					end
				end
				ST_EVICT: begin
					valid_q[walk_idx_q] <= 1'b0;
					if (cnt_q == CW'(1)) begin
						state_q <= ST_PMOD;
					end
				end
				ST_PMOD: begin
					if (mod_sts.done) begin
						valid_q[mod_idx] <= 1'b1;
						next_q           <= seq_q + SEQ_W'(1);
						state_q          <= ST_IDLE;
					end
				end
				ST_LCHK: begin
					state_q <= ST_LLEN;
				end
				ST_LLEN: begin
					pend_vld_q <= 1'b0;
					if (seq_q < end_q) begin
						state_q <= ST_LMOD;
					end else begin
						state_q <= ST_LAST;
					end
				end
				ST_LMOD: begin
					if (mod_sts.done) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (walk_hit) begin
						state_q <= ST_RDATA;
					end else if (cnt_q == CW'(1)) begin
						state_q <= ST_LAST;
					end
				end
				ST_RDATA: begin
					if (!pend_vld_q || out_free) begin
						pend_vld_q <= 1'b1;
						if (cnt_q == '0) begin
							state_q <= ST_LAST;
						end else begin
							state_q <= ST_WALK;
						end
					end
				end
				ST_LAST: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request and walk datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					req_q <= req_type;
					seq_q <= seq_num;
					end_q <= range_end;
					pay_q <= payload;
				end
			end
			ST_PCHK: begin
				cnt_q <= nclr;
				// a push has no range end, so it tracks the evicted sequence
				end_q <= oldest_q;
			end
			ST_EVMOD: begin
				if (mod_sts.done) begin
					walk_idx_q <= mod_idx;
				end
			end
			ST_EVICT: begin
				// a sequence wrapping to zero always lands on slot zero
				if (&end_q) begin
					walk_idx_q <= '0;
				end else begin
					walk_idx_q <= walk_idx_nx;
				end
				end_q <= end_q + SEQ_W'(1);
				cnt_q <= cnt_q - CW'(1);
			end
			ST_LCHK: begin
				// clamp the range to the held window
				if (seq_q < oldest_q) begin
					seq_q <= oldest_q;
				end
				if (end_q > next_q) begin
					end_q <= next_q;
				end
			end
			ST_LLEN: begin
				cnt_q <= len;
			end
			ST_LMOD: begin
				if (mod_sts.done) begin
					walk_idx_q <= mod_idx;
				end
			end
			ST_WALK: begin
				cnt_q <= cnt_q - CW'(1);
				if (!walk_hit) begin
					walk_idx_q <= walk_idx_nx;
					seq_q      <= seq_q + SEQ_W'(1);
				end
			end
			ST_RDATA: begin
				if (!pend_vld_q || out_free) begin
					pend_seq_q <= seq_q;
					pend_pay_q <= rdata_q;
					walk_idx_q <= walk_idx_nx;
					seq_q      <= seq_q + SEQ_W'(1);
				end
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	// payload memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if ((state_q == ST_PMOD) && mod_sts.done && (req_q == REQ_PUSH)) begin
			mem[mod_idx] <= pay_q;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_WALK) && walk_hit) begin
			rdata_q <= mem[walk_idx_q];
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			present_q <= ld_present;
			out_seq_q <= ld_seq;
			out_pay_q <= ld_pay;
			last_q    <= ld_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign present     = present_q;
	assign out_seq     = out_seq_q;
	assign out_payload = out_pay_q;
	assign last        = last_q;

`ifndef ASSERT_OFF
	// a waiting result word is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !(out_valid_q && out_stall))
		else $error("result word overwritten while stalled");

	// the remainder unit is only started when free
	a_mod_free: assert property (@(posedge clk) disable iff (!arst_n)
		mod_start |-> !mod_sts.busy)
		else $error("remainder unit restarted while busy");

	// a remainder only arrives in a state that waits for it
	a_mod_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mod_sts.done |-> (state_q == ST_EVMOD || state_q == ST_PMOD ||
			state_q == ST_LMOD))
		else $error("remainder arrived outside a wait state");

	// walk and eviction counts never run out mid-walk
	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVICT || state_q == ST_WALK) |-> (cnt_q != '0))
		else $error("walk count exhausted inside walk");

	// walk index stays inside the ring in use
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK || state_q == ST_EVICT) |-> (CW'(walk_idx_q) < cap_eff))
		else $error("walk index outside capacity");
`endif

endmodule : sequence_retransmit_buffer_unit
`default_nettype wire

>>> tb/sequence_retransmit_buffer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequence retransmit buffer testbench
// Drives push, pull, flush and idle request words in bursts, checks every
// pulled entry against a cycle-free model of the slot ring, and steps the
// capacity register through its extremes between idle phases.
// ----------------------------------------------------------------------------
module sequence_retransmit_buffer_unit_tb;
	import srb_pkg::*;

	localparam int SLOTS          = SLOTS_DEF;
	localparam int PHASE_WORDS    = 22;
	localparam int SETTLE_CYCLES  = 150;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct {
		req_t             kind;
		logic [SEQ_W-1:0] seq;
		logic [SEQ_W-1:0] range_hi;
		logic [PAY_W-1:0] handle;
	} request_t;

	typedef struct {
		logic             present;
		logic [SEQ_W-1:0] seq;
		logic [PAY_W-1:0] handle;
		logic             last;
	} entry_t;

	// DUT signals
	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             cfg_wr_en   = 1'b0;
	logic [CAP_W-1:0] cfg_wr_data = '0;
	logic             in_valid    = 1'b0;
	logic             in_stall;
	logic [REQ_W-1:0] req_type    = REQ_NOP;
	logic [SEQ_W-1:0] seq_num     = '0;
	logic [SEQ_W-1:0] range_end   = '0;
	logic [PAY_W-1:0] payload     = '0;
	logic             out_valid;
	logic             out_stall   = 1'b0;
	logic             present;
	logic [SEQ_W-1:0] out_seq;
	logic [PAY_W-1:0] out_payload;
	logic             last;

	// stimulus and scoreboard
	request_t         request_backlog [$];
	entry_t           due_entries [$];
	request_t         cur_req;
	int unsigned      words_queued = 0;
	int unsigned      words_taken  = 0;
	int               gap_left     = 0;
	int               burst_left   = 0;
	int               err_count    = 0;
	int               quiet_cycles = 0;
	logic [31:0]      rx_tick      = '0;
	logic [SEQ_W-1:0] plan_next    = '0;

	// model of the slot ring
	logic [CAP_W-1:0] cap_reg = CAP_RESET;
	logic [PAY_W-1:0] slot_handle [SLOTS];
	bit               slot_held [SLOTS];
	logic [SEQ_W-1:0] win_oldest = '0;
	logic [SEQ_W-1:0] win_next   = '0;

	sequence_retransmit_buffer_unit #(
		.SLOTS(SLOTS)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.seq_num    (seq_num),
		.range_end  (range_end),
		.payload    (payload),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.present    (present),
		.out_seq    (out_seq),
		.out_payload(out_payload),
		.last       (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// capacity as the ring uses it: 0 acts as 1, above SLOTS acts as SLOTS
	function automatic int unsigned eff_cap();
		if (cap_reg == '0)
			return 1;
		if (cap_reg > SLOTS)
			return SLOTS;
		return cap_reg;
	endfunction

	// store one entry, evicting the oldest ones when the window overflows
	function automatic void window_push(logic [SEQ_W-1:0] seq, logic [PAY_W-1:0] handle);
		int unsigned      cap;
		logic [32:0]      span;
		logic [32:0]      excess;
		logic [32:0]      nclr;
		logic [SEQ_W-1:0] s;
		cap = eff_cap();
		if (seq < win_next)
			return;
		span = {1'b0, seq - win_oldest} + 33'd1;
		if (span > cap) begin
			excess = span - cap;
			nclr = (excess < cap) ? excess : cap;
			for (int unsigned i = 0; i < nclr; i++) begin
				s = win_oldest + i;
				slot_held[s % cap] = 1'b0;
			end
			win_oldest = win_oldest + excess[31:0];
		end
		slot_handle[seq % cap] = handle;
		slot_held[seq % cap] = 1'b1;
		win_next = seq + 1;
	endfunction

	// walk the clamped range and queue every held entry, or one empty marker
	function automatic void window_pull(logic [SEQ_W-1:0] from, logic [SEQ_W-1:0] upto);
		int unsigned      cap;
		logic [SEQ_W-1:0] lo;
		logic [SEQ_W-1:0] hi;
		logic [SEQ_W-1:0] len;
		logic [SEQ_W-1:0] s;
		entry_t           found [$];
		entry_t           e;
		cap = eff_cap();
		lo = (from < win_oldest) ? win_oldest : from;
		hi = (upto > win_next) ? win_next : upto;
		if (lo < hi) begin
			len = hi - lo;
			if (len > cap)
				len = cap;
			for (int unsigned i = 0; i < len; i++) begin
				s = lo + i;
				if (slot_held[s % cap]) begin
					e.present = 1'b1;
					e.seq = s;
					e.handle = slot_handle[s % cap];
					e.last = 1'b0;
					found.push_back(e);
				end
			end
		end
		if (found.size() == 0) begin
			e.present = 1'b0;
			e.seq = '0;
			e.handle = '0;
			e.last = 1'b1;
			found.push_back(e);
		end else begin
			found[found.size() - 1].last = 1'b1;
		end
		foreach (found[i])
			due_entries.push_back(found[i]);
	endfunction

	function automatic void window_apply(request_t r);
		case (r.kind)
			REQ_PUSH: window_push(r.seq, r.handle);
			REQ_PULL: window_pull(r.seq, r.range_hi);
			REQ_FLUSH: begin
				foreach (slot_held[i])
					slot_held[i] = 1'b0;
				win_oldest = '0;
				win_next = '0;
			end
			default: ;
		endcase
	endfunction

	// append a word and track where the window will end up
	function automatic void queue_request(req_t kind, logic [SEQ_W-1:0] seq,
			logic [SEQ_W-1:0] range_hi, logic [PAY_W-1:0] handle);
		request_t r;
		r.kind = kind;
		r.seq = seq;
		r.range_hi = range_hi;
		r.handle = handle;
		request_backlog.push_back(r);
		words_queued++;
		if (kind == REQ_PUSH && seq >= plan_next)
			plan_next = seq + 1;
		else if (kind == REQ_FLUSH)
			plan_next = '0;
	endfunction

	// mostly in-order pushes and pulls near the window; returns 0 for ignored words
	function automatic bit queue_random_word();
		int unsigned      cap;
		int unsigned      pick;
		logic [SEQ_W-1:0] from;
		cap = eff_cap();
		pick = $urandom_range(0, 99);
		if (pick < 48) begin
			if ($urandom_range(0, 9) == 0)
				queue_request(REQ_PUSH, plan_next + $urandom_range(0, 3 * cap), $urandom, $urandom);
			else
				queue_request(REQ_PUSH, plan_next + $urandom_range(0, 2), $urandom, $urandom);
			return 1'b1;
		end
		if (pick < 76) begin
			from = plan_next - $urandom_range(0, cap + 4);
			queue_request(REQ_PULL, from, from + $urandom_range(0, cap + 6), $urandom);
			return 1'b1;
		end
		if (pick < 82) begin
			// stale push
			queue_request(REQ_PUSH, plan_next - $urandom_range(1, 5), $urandom, $urandom);
			return 1'b0;
		end
		if (pick < 86) begin
			// far jump, sometimes right below the top of the sequence space
			if ($urandom_range(0, 1) == 1)
				queue_request(REQ_PUSH, $urandom, $urandom, $urandom);
			else
				queue_request(REQ_PUSH, 32'hFFFF_FFFF - $urandom_range(0, 6), $urandom, $urandom);
			return 1'b1;
		end
		if (pick < 90) begin
			queue_request(REQ_FLUSH, $urandom, $urandom, $urandom);
			return 1'b1;
		end
		if (pick < 94) begin
			queue_request(REQ_NOP, $urandom, $urandom, $urandom);
			return 1'b0;
		end
		queue_request(REQ_PULL, $urandom, $urandom, $urandom);
		return 1'b1;
	endfunction

	// block is idle here, so the model takes the new value at once
	task automatic write_capacity(logic [CAP_W-1:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		cap_reg = value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// wait until every word is taken and every entry returned, then let a
	// trailing push finish its eviction
	task automatic settle();
		while (words_taken != words_queued || due_entries.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// request driver: bursts of words with random gaps between them
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				window_apply(cur_req);
				words_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0 || request_backlog.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					in_valid <= 1'b0;
				end else begin
					cur_req = request_backlog.pop_front();
					in_valid <= 1'b1;
					req_type <= cur_req.kind;
					seq_num <= cur_req.seq;
					range_end <= cur_req.range_hi;
					payload <= cur_req.handle;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 12);
						gap_left = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 6) : 0;
					end
				end
			end
		end
	end

	// result stall pattern: free, light random, periodic runs, heavy random
	always @(posedge clk) begin
		rx_tick = rx_tick + 1;
		case (rx_tick[9:8])
			2'd0: out_stall <= 1'b0;
			2'd1: out_stall <= ($urandom_range(0, 3) == 0);
			2'd2: out_stall <= (rx_tick[4:0] < 5'd12);
			default: out_stall <= ($urandom_range(0, 9) < 7);
		endcase
	end

	// result monitor
	always @(posedge clk) begin
		entry_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_entries.size() == 0) begin
				$error("unexpected result word: seq %0h payload %0h", out_seq, out_payload);
				err_count++;
			end else begin
				want = due_entries.pop_front();
				if (present !== want.present) begin
					$error("present: expected %0d, got %0d", want.present, present);
					err_count++;
				end
				if (out_seq !== want.seq) begin
					$error("out_seq: expected %0h, got %0h", want.seq, out_seq);
					err_count++;
				end
				if (out_payload !== want.handle) begin
					$error("out_payload: expected %0h, got %0h", want.handle, out_payload);
					err_count++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, last);
					err_count++;
				end
			end
		end
	end

	// watchdog on cycles with no word moving on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [CAP_W-1:0] cap_plan [8];
		int               words;
		cap_plan = '{6'd5, 6'd0, 6'd1, 6'd63, 6'd33, 6'd17, 6'd2, 6'd32};
		cap_plan[7] = $urandom_range(3, 31);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// empty ring, holes, stale and repeated pushes
		queue_request(REQ_PULL, '0, '1, '0);
		queue_request(REQ_PUSH, '0, '0, '1);
		queue_request(REQ_PUSH, 32'd1, '1, '0);
		queue_request(REQ_PUSH, 32'd5, '0, 32'hA5A5_5A5A);
		queue_request(REQ_PUSH, 32'd3, '0, 32'h1111_1111);
		queue_request(REQ_PUSH, 32'd5, '0, 32'h2222_2222);
		queue_request(REQ_PULL, '0, '1, '1);
		queue_request(REQ_PULL, 32'd2, 32'd5, '0);
		queue_request(REQ_PULL, 32'd6, 32'd2, '0);
		queue_request(REQ_NOP, '1, '1, '1);
		// eviction, then an excess larger than the capacity
		queue_request(REQ_PUSH, 32'd40, '0, 32'h0000_0040);
		queue_request(REQ_PULL, '0, 32'd100, '0);
		queue_request(REQ_PUSH, 32'd200, '0, 32'hDEAD_BEEF);
		queue_request(REQ_PULL, 32'd150, 32'd201, '0);
		// next mark wraps past the top, leaving the window inverted
		queue_request(REQ_PUSH, 32'hFFFF_FFFE, '0, 32'h8000_0001);
		queue_request(REQ_PUSH, 32'hFFFF_FFFF, '0, 32'h7FFF_FFFE);
		queue_request(REQ_PULL, 32'hFFFF_FFF0, '1, '0);
		queue_request(REQ_PUSH, 32'd2, '0, 32'h0BAD_F00D);
		queue_request(REQ_PULL, '0, '1, '0);
		// flush and restart from zero
		queue_request(REQ_FLUSH, 32'd7, 32'd7, 32'd7);
		queue_request(REQ_PULL, '0, '1, '0);
		queue_request(REQ_PUSH, '0, '0, 32'h1234_5678);
		queue_request(REQ_PULL, '0, 32'd1, '0);
		settle();

		// random phases, one capacity each; the ring keeps its contents across
		foreach (cap_plan[p]) begin
			write_capacity(cap_plan[p]);
			words = 0;
			while (words < PHASE_WORDS)
				words += queue_random_word();
			settle();
		end

		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
